// ===== rtl/core/tst_pkg.sv =====
// Package for the timed signal table: request codes, table size and the
// control structs passed between the top level and the slot table.
// No dependencies.
package tst_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EPOCH_W    = 32;
    localparam int CODE_W     = 8;
    localparam int MASK_W     = 8;
    localparam int ADD_SLOT_W = 3;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SCAN  = 2'd1,
        REQ_ADD   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    // Command from the top level to the slot table for one request.
    typedef struct packed {
        logic                 en;
        req_type_t            req_type;
        logic [EPOCH_W-1:0]   epoch;
        logic [EPOCH_W-1:0]   due_time;
        logic [CODE_W-1:0]    code;
    } slot_cmd_t;

    // Outcome of that request as seen by the slot table.
    typedef struct packed {
        logic [SLOTS-1:0]      fired;
        logic                  add_ok;
        logic [SLOT_IDX_W-1:0] add_idx;
        logic [SLOTS-1:0]      busy_next;
    } slot_status_t;

endpackage

// ===== rtl/core/tst_req_if.sv =====
// Request channel of the timed signal table: valid/ready plus payload.
// Depends on tst_pkg.
interface tst_req_if;
    import tst_pkg::*;

    logic                valid;
    logic                ready;
    req_type_t           req_type;
    logic [EPOCH_W-1:0]  delay_ticks;
    logic [CODE_W-1:0]   signal_code;

    modport source (output valid, output req_type, output delay_ticks,
                    output signal_code, input ready);
    modport sink   (input valid, input req_type, input delay_ticks,
                    input signal_code, output ready);
endinterface

// ===== rtl/core/tst_rsp_if.sv =====
// Result channel of the timed signal table: valid/ready plus payload.
// Depends on tst_pkg.
interface tst_rsp_if;
    import tst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [EPOCH_W-1:0]    epoch_now;
    logic [MASK_W-1:0]     fired_mask;
    logic                  add_accepted;
    logic [ADD_SLOT_W-1:0] add_slot;
    logic [MASK_W-1:0]     busy_mask;

    modport source (output valid, output epoch_now, output fired_mask,
                    output add_accepted, output add_slot, output busy_mask,
                    input ready);
    modport sink   (input valid, input epoch_now, input fired_mask,
                    input add_accepted, input add_slot, input busy_mask,
                    output ready);
endinterface

// ===== rtl/core/tst_slot_table.sv =====
// Slot storage of the timed signal table with the per-slot compare,
// lowest-free-slot encoder and update logic.
// Depends on tst_pkg.
module tst_slot_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tst_pkg::slot_cmd_t    cmd,
    output tst_pkg::slot_status_t status
);
    import tst_pkg::*;

    logic [CODE_W-1:0]  code_reg [SLOTS];
    logic [EPOCH_W-1:0] due_reg  [SLOTS];
    logic [SLOTS-1:0]   free_reg;
    logic [SLOTS-1:0]   fired_reg;
    logic [SLOTS-1:0]   free_next;
    logic [SLOTS-1:0]   fired_next;

    logic [SLOTS-1:0]      hit;
    logic [SLOTS-1:0]      match;
    logic                  any_free;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOTS-1:0]      add_sel;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i]   = !free_reg[i] && !fired_reg[i] && (due_reg[i] == cmd.epoch);
            match[i] = !free_reg[i] && (code_reg[i] == cmd.code);
        end
    end

    // Walking down from the top leaves the lowest free slot selected.
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_idx = SLOT_IDX_W'(i);
            end
        end
        any_free = |free_reg;
        add_sel  = '0;
        if (cmd.en && cmd.req_type == REQ_ADD && any_free)
        begin
            add_sel[free_idx] = 1'b1;
        end
    end

    always_comb
    begin
        free_next  = free_reg;
        fired_next = fired_reg;
        if (cmd.en)
        begin
            case (cmd.req_type)
                REQ_SCAN:
                begin
                    fired_next = fired_reg | hit;
                end
                REQ_ADD:
                begin
                    free_next  = free_reg & ~add_sel;
                    fired_next = fired_reg & ~add_sel;
                end
                REQ_CLEAR:
                begin
                    free_next  = free_reg | match;
                    fired_next = fired_reg & ~match;
                end
                default:
                begin
                    free_next  = free_reg;
                    fired_next = fired_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '1;
            fired_reg <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            fired_reg <= fired_next;
        end
    end

    // Code and due time are only read while a slot is occupied.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (add_sel[i])
            begin
                code_reg[i] <= cmd.code;
                due_reg[i]  <= cmd.due_time;
            end
        end
    end

    always_comb
    begin
        status.fired     = (cmd.req_type == REQ_SCAN) ? hit : '0;
        status.add_ok    = (cmd.req_type == REQ_ADD) && any_free;
        status.add_idx   = status.add_ok ? free_idx : '0;
        status.busy_next = ~free_next;
    end

endmodule

// ===== rtl/core/timed_signal_table.sv =====
// Timed signal table: top level with the request register, epoch counter
// and result register. Depends on tst_pkg, tst_req_if, tst_rsp_if and
// tst_slot_table.
//
// The block takes one request per cycle while the result side does not stall
// and returns one result per request, in order. A request is captured in an
// input register, the slot table then compares all eight slots in parallel and
// updates them, and the result lands in the output register. The output
// register lets a new request enter while a result waits; when the result
// side stalls, one request waits in the input register and then ready drops.
// After reset the epoch is zero and every slot is free.
module timed_signal_table (
    input  logic          clk,
    input  logic          rst_n,
    tst_req_if.sink       req,
    tst_rsp_if.source     rsp
);
    import tst_pkg::*;

    logic                  in_valid_reg;
    req_type_t             req_type_reg;
    logic [EPOCH_W-1:0]    delay_reg;
    logic [CODE_W-1:0]     code_reg;

    logic [EPOCH_W-1:0]    epoch_reg;
    logic [EPOCH_W-1:0]    epoch_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [EPOCH_W-1:0]    epoch_now_reg;
    logic [MASK_W-1:0]     fired_mask_reg;
    logic                  add_accepted_reg;
    logic [ADD_SLOT_W-1:0] add_slot_reg;
    logic [MASK_W-1:0]     busy_mask_reg;

    logic                  advance;
    logic                  take_in;
    slot_cmd_t             cmd;
    slot_status_t          status;
    logic [63:0]           fired_wide;
    logic [63:0]           busy_wide;
    logic [63:0]           idx_wide;

    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take_in = req.valid && req.ready;

    always_comb
    begin
        cmd.en       = advance;
        cmd.req_type = req_type_reg;
        cmd.epoch    = epoch_reg;
        cmd.due_time = epoch_reg + delay_reg;
        cmd.code     = code_reg;
    end

    tst_slot_table u_slot_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    always_comb
    begin
        epoch_next = epoch_reg;
        if (advance && req_type_reg == REQ_TICK)
        begin
            epoch_next = epoch_reg + 1'b1;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        // The mask and index fields are as wide as the slot count and slot index, so results carry every slot.
        fired_wide = 64'(status.fired);
        busy_wide  = 64'(status.busy_next);
        idx_wide   = 64'(status.add_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            epoch_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            out_valid_reg <= out_valid_next;
            epoch_reg     <= epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            req_type_reg <= req.req_type;
            delay_reg    <= req.delay_ticks;
            code_reg     <= req.signal_code;
        end
        if (advance)
        begin
            epoch_now_reg    <= epoch_next;
            fired_mask_reg   <= fired_wide[MASK_W-1:0];
            add_accepted_reg <= status.add_ok;
            add_slot_reg     <= idx_wide[ADD_SLOT_W-1:0];
            busy_mask_reg    <= busy_wide[MASK_W-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.epoch_now    = epoch_now_reg;
    assign rsp.fired_mask   = fired_mask_reg;
    assign rsp.add_accepted = add_accepted_reg;
    assign rsp.add_slot     = add_slot_reg;
    assign rsp.busy_mask    = busy_mask_reg;

endmodule

// ===== rtl/core/tst_checker.sv =====
// Port-level checks for the timed signal table, attached by bind.
// Depends on tst_pkg and timed_signal_table.
module tst_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [tst_pkg::EPOCH_W-1:0]    epoch_now,
    input logic [tst_pkg::MASK_W-1:0]     fired_mask,
    input logic                           add_accepted,
    input logic [tst_pkg::ADD_SLOT_W-1:0] add_slot,
    input logic [tst_pkg::MASK_W-1:0]     busy_mask
);
    import tst_pkg::*;

    // A stalled result keeps its epoch, fired mask and busy mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(epoch_now)
            && $stable(busy_mask) && $stable(fired_mask))
        else $error("stalled result changed");

    // A dropped add or a non-add request reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !add_accepted |-> add_slot == '0)
        else $error("add_slot nonzero without accepted add");

    // A scan never also reports an add.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && fired_mask != '0 |-> !add_accepted)
        else $error("scan result also reports an add");

    // The slot that took an add is occupied afterwards, and so is every fired slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && add_accepted |-> busy_mask[add_slot])
        else $error("accepted slot not busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (fired_mask & ~busy_mask) == '0)
        else $error("fired slot not busy");

endmodule

bind timed_signal_table tst_checker u_tst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .epoch_now    (rsp.epoch_now),
    .fired_mask   (rsp.fired_mask),
    .add_accepted (rsp.add_accepted),
    .add_slot     (rsp.add_slot),
    .busy_mask    (rsp.busy_mask)
);
